@@ rtl/adl_pkg.sv @@
// Package for the ADC block averager: widths, register indexes and the
// structs passed between the front, queue and back modules. No dependencies.
package adl_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int LEVEL_W     = 8;
  localparam int SUM_W       = 16;
  localparam int CNT_W       = 8;
  localparam int MAX_SAMPLES = 255;

  // Configuration port
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_ABSENT   = 3'd4;

  // Job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  // One completed run: rounded dividend and the number of samples in it.
  typedef struct packed {
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } adl_job_t;

  // Registers used by the back end.
  typedef struct packed {
    logic               invert_enable;
    logic [LEVEL_W-1:0] lower_bound;
    logic [LEVEL_W-1:0] upper_bound;
    logic               pot_absent;
  } adl_cfg_t;

  // Back end status toward the top level.
  typedef struct packed {
    logic busy;
    logic load;
  } adl_back_stat_t;

endpackage

@@ rtl/adl_front.sv @@
// Front end of the ADC block averager: accumulates samples and, when a run
// completes, queues a divide job. Depends on adl_pkg.
module adl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [adl_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [adl_pkg::CNT_W-1:0]    sample_count,
  input  logic                         q_full,
  output logic                         q_push,
  output adl_pkg::adl_job_t            q_job
);
  import adl_pkg::*;

  logic [SUM_W-1:0] sum_acc_r, sum_acc_nxt;
  logic [CNT_W-1:0] taken_count_r, taken_count_nxt;
  logic [CNT_W-1:0] eff_count;
  logic [CNT_W:0]   taken;
  logic [SUM_W-1:0] sum;
  logic             accept;
  logic             run_done;

  always_comb begin
    eff_count = sample_count;
    if (eff_count == '0) begin
      eff_count = CNT_W'(1);
    end
    if (32'(eff_count) > MAX_SAMPLES) begin
      eff_count = CNT_W'(MAX_SAMPLES);
    end
  end

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign taken    = {1'b0, taken_count_r} + (CNT_W+1)'(1);
  assign sum      = sum_acc_r + SUM_W'(in_sample);
  assign run_done = taken >= {1'b0, eff_count};

  // A run never holds more than MAX_SAMPLES samples, so the rounded sum
  // stays within SUM_W bits.
  assign q_push         = accept && run_done;
  assign q_job.dividend = sum + SUM_W'(taken[CNT_W:1]);
  assign q_job.divisor  = taken[CNT_W-1:0];

  always_comb begin
    sum_acc_nxt     = sum_acc_r;
    taken_count_nxt = taken_count_r;
    if (accept) begin
      if (run_done) begin
        sum_acc_nxt     = '0;
        taken_count_nxt = '0;
      end else begin
        sum_acc_nxt     = sum;
        taken_count_nxt = taken[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_acc_r     <= '0;
      taken_count_r <= '0;
    end else begin
      sum_acc_r     <= sum_acc_nxt;
      taken_count_r <= taken_count_nxt;
    end
  end

endmodule

@@ rtl/adl_queue.sv @@
// Short job queue between the front and back of the ADC block averager.
// Depends on adl_pkg.
module adl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  adl_pkg::adl_job_t wr_job,
  output logic              q_full,
  input  logic              rd_en,
  output adl_pkg::adl_job_t rd_job,
  output logic              q_empty
);
  import adl_pkg::*;

  adl_job_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + Q_PTR_W'(1);
  endfunction

  assign q_full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign q_empty = cnt_r == '0;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/adl_back.sv @@
// Back end of the ADC block averager: serial restoring divide, inversion,
// bound clamping and the result register. Depends on adl_pkg.
module adl_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  adl_pkg::adl_job_t           q_job,
  output logic                        q_pop,
  input  adl_pkg::adl_cfg_t           cfg,
  output logic                        empty,
  input  logic                        pop,
  output logic [adl_pkg::LEVEL_W-1:0] out_level,
  output adl_pkg::adl_back_stat_t     stat
);
  import adl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      dvs_r, dvs_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]    level_r, level_nxt;

  logic [CNT_W:0]        rem_sh;
  logic [CNT_W:0]        rem_diff;
  logic                  fits;
  logic                  load;
  logic [LEVEL_W-1:0]    avg;
  logic [LEVEL_W-1:0]    lvl;

  // One quotient bit per step; the remainder always stays below the divisor.
  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign fits     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    avg = (|quo_r[SUM_W-1:LEVEL_W]) ? '1 : quo_r[LEVEL_W-1:0];
    lvl = cfg.invert_enable ? ~avg : avg;
    if (lvl <= cfg.lower_bound) begin
      lvl = '0;
    end else if (lvl >= cfg.upper_bound) begin
      lvl = '1;
    end
    if (cfg.pot_absent) begin
      lvl = '1;
    end
  end

  assign load = (state_r == ST_DONE) && (!out_valid_r || pop);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          quo_nxt   = q_job.dividend;
          dvs_nxt   = q_job.divisor;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt  = {quo_r[SUM_W-2:0], fits};
        rem_nxt  = fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        step_nxt = step_r + DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      level_nxt     = lvl;
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    level_r <= level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty     = !out_valid_r;
  assign out_level = level_r;
  assign stat.busy = state_r != ST_IDLE;
  assign stat.load = load;

endmodule

@@ rtl/adc_average_deadband_level.sv @@
// Top level of the ADC block averager with rounding and deadband clamp.
// Depends on adl_pkg, adl_front, adl_queue and adl_back.

// The block sums 8-bit converter samples and, after sample_count of them,
// emits one level: the run's sum divided by its sample count, rounded half
// up, then bit-inverted if invert_enable is set, forced to 0 at or below
// lower_bound and otherwise to 255 at or above upper_bound; pot_absent
// forces every emitted level to 255. A sample_count of 0 acts as 1. A
// sample transaction is taken at once whenever the job queue has room, so
// samples stream in at one per cycle until the queue fills. Each completed
// run is handed through a two-entry job queue to a serial restoring divider
// that yields one quotient bit per clock: the back end loads the job, runs
// 16 divide steps and then writes the level into the result register once
// that register is empty or being popped, and it takes no new job until
// that level is in. The accumulator and counter clear after each completed
// run; configuration writes leave them alone and must be made while no
// result is pending.
module adc_average_deadband_level (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [adl_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           empty,
  input  logic                           pop,
  output logic [adl_pkg::LEVEL_W-1:0]    out_level,
  input  logic                           cfg_we,
  input  logic [adl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import adl_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0]   sample_count_r, sample_count_nxt;
  logic               invert_enable_r, invert_enable_nxt;
  logic [LEVEL_W-1:0] lower_bound_r, lower_bound_nxt;
  logic [LEVEL_W-1:0] upper_bound_r, upper_bound_nxt;
  logic               pot_absent_r, pot_absent_nxt;

  adl_cfg_t       back_cfg;
  adl_back_stat_t back_stat;
  adl_job_t       front_job;
  adl_job_t       queue_job;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  // Register write decode. Writes to an unknown index are dropped.
  always_comb begin
    sample_count_nxt  = sample_count_r;
    invert_enable_nxt = invert_enable_r;
    lower_bound_nxt   = lower_bound_r;
    upper_bound_nxt   = upper_bound_r;
    pot_absent_nxt    = pot_absent_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_nxt  = cfg_data[CNT_W-1:0];
        CFG_INVERT:       invert_enable_nxt = cfg_data[0];
        CFG_LOWER_BOUND:  lower_bound_nxt   = cfg_data[LEVEL_W-1:0];
        CFG_UPPER_BOUND:  upper_bound_nxt   = cfg_data[LEVEL_W-1:0];
        CFG_POT_ABSENT:   pot_absent_nxt    = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= CNT_W'(1);
      invert_enable_r <= 1'b0;
      lower_bound_r   <= '0;
      upper_bound_r   <= '1;
      pot_absent_r    <= 1'b0;
    end else begin
      sample_count_r  <= sample_count_nxt;
      invert_enable_r <= invert_enable_nxt;
      lower_bound_r   <= lower_bound_nxt;
      upper_bound_r   <= upper_bound_nxt;
      pot_absent_r    <= pot_absent_nxt;
    end
  end

  assign back_cfg.invert_enable = invert_enable_r;
  assign back_cfg.lower_bound   = lower_bound_r;
  assign back_cfg.upper_bound   = upper_bound_r;
  assign back_cfg.pot_absent    = pot_absent_r;

  // The front end accumulates and detects the end of a run.
  adl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_sample    (in_sample),
    .sample_count (sample_count_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (front_job)
  );

  // Completed runs wait here while the divider is busy.
  adl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_job  (front_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_job  (queue_job),
    .q_empty (q_empty)
  );

  // The back end divides, post-processes and holds the result transaction.
  adl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (queue_job),
    .q_pop     (q_pop),
    .cfg       (back_cfg),
    .empty     (empty),
    .pop       (pop),
    .out_level (out_level),
    .stat      (back_stat)
  );

  // A completed run is never pushed into a full job queue.
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // The back end only takes a job when it is idle and one is waiting.
  a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && !back_stat.busy))
    else $error("job taken from empty queue or while busy");

  // With no input fitted, every loaded result reads full scale.
  a_pot_absent_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (back_stat.load && pot_absent_r) |=> (out_level == '1))
    else $error("level not full scale with input absent");

endmodule
